FILE: src/pidpc_pkg.sv
// ----------------------------------------------------------------------------
// pidpc_pkg
// Shared types, constants and helpers for the positional pid controller.
// ----------------------------------------------------------------------------
package pidpc_pkg;

  localparam int unsigned BANG_FRACTION_Q8 = 230;
  localparam int unsigned SOFT_FRACTION_Q8 = 26;
  localparam logic [31:0] TARGET_DEADBAND  = 32'd655;

  // register indexes on the configuration port
  localparam logic [2:0] REG_KP    = 3'd0;
  localparam logic [2:0] REG_KI    = 3'd1;
  localparam logic [2:0] REG_KD    = 3'd2;
  localparam logic [2:0] REG_DT    = 3'd3;
  localparam logic [2:0] REG_ILIM  = 3'd4;
  localparam logic [2:0] REG_DLIM  = 3'd5;
  localparam logic [2:0] REG_OLIM  = 3'd6;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_MUL_P,
    OP_MUL_I,
    OP_ACC_I,
    OP_MUL_K,
    OP_MUL_D,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_SUM,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } status_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -66'sd2147483648) begin
      r = -32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

FILE: src/pidpc_ctrl.sv
// ----------------------------------------------------------------------------
// pidpc_ctrl
// Sequencer: walks one sample through the shared multiplier and divider.
// ----------------------------------------------------------------------------
module pidpc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pidpc_pkg::status_t status,
  output pidpc_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ERR, ST_MUL_P, ST_MUL_I, ST_ACC_I, ST_MUL_K, ST_MUL_D,
    ST_DIV_START, ST_DIV_STEP, ST_SUM, ST_OUT
  } state_t;

  state_t state;

  assign in_ready = (state == ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:      if (in_valid) state <= ST_ERR;
        ST_ERR:       state <= ST_MUL_P;
        ST_MUL_P:     state <= ST_MUL_I;
        ST_MUL_I:     state <= ST_ACC_I;
        ST_ACC_I:     state <= ST_MUL_K;
        ST_MUL_K:     state <= ST_MUL_D;
        ST_MUL_D:     state <= ST_DIV_START;
        ST_DIV_START: state <= ST_DIV_STEP;
        ST_DIV_STEP:  if (status.div_last) state <= ST_SUM;
        ST_SUM:       state <= ST_OUT;
        ST_OUT:       if (!status.out_busy) state <= ST_IDLE;
        default:      state <= ST_IDLE;
      endcase
    end
  end

  // operation decode
  always_comb begin
    cmd.op = pidpc_pkg::OP_NONE;
    case (state)
      ST_IDLE:      if (in_valid) cmd.op = pidpc_pkg::OP_LOAD;
      ST_ERR:       cmd.op = pidpc_pkg::OP_ERR;
      ST_MUL_P:     cmd.op = pidpc_pkg::OP_MUL_P;
      ST_MUL_I:     cmd.op = pidpc_pkg::OP_MUL_I;
      ST_ACC_I:     cmd.op = pidpc_pkg::OP_ACC_I;
      ST_MUL_K:     cmd.op = pidpc_pkg::OP_MUL_K;
      ST_MUL_D:     cmd.op = pidpc_pkg::OP_MUL_D;
      ST_DIV_START: cmd.op = pidpc_pkg::OP_DIV_START;
      ST_DIV_STEP:  cmd.op = pidpc_pkg::OP_DIV_STEP;
      ST_SUM:       cmd.op = pidpc_pkg::OP_SUM;
      ST_OUT:       if (!status.out_busy) cmd.op = pidpc_pkg::OP_OUT;
      default:      cmd.op = pidpc_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: src/pidpc_datapath.sv
// ----------------------------------------------------------------------------
// pidpc_datapath
// Configuration registers, controller state, shared multiplier, bit-serial
// divider and output register.
// ----------------------------------------------------------------------------
module pidpc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [63:0]         in_data,
  input  pidpc_pkg::cmd_t     cmd,
  output pidpc_pkg::status_t  status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_drive,
  output logic                out_bang
);

  // configuration
  logic signed [31:0] kp, ki, kd;
  logic [30:0]        period;
  logic [29:0]        ilim;
  logic [30:0]        dlim, olim;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= '0; ki <= '0; kd <= '0;
      period <= 31'd65536;
      ilim <= '0; dlim <= '0; olim <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pidpc_pkg::REG_KP:   kp <= cfg_data;
        pidpc_pkg::REG_KI:   ki <= cfg_data;
        pidpc_pkg::REG_KD:   kd <= cfg_data;
        pidpc_pkg::REG_DT:   period <= cfg_data[30:0];
        pidpc_pkg::REG_ILIM: ilim <= cfg_data[29:0];
        pidpc_pkg::REG_DLIM: dlim <= cfg_data[30:0];
        pidpc_pkg::REG_OLIM: olim <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic [30:0] dt;
  assign dt = (period == '0) ? 31'd1 : period;

  // sample and working registers
  logic signed [31:0] sp, meas, target, e0, e1, isum, h0, h1, h2;
  logic signed [31:0] pterm, iterm, u;
  logic               sep, neg;
  logic signed [65:0] prod;
  logic [63:0]        num;
  logic [30:0]        rem;
  logic [5:0]         div_cnt;

  // target deadband and new error
  logic signed [32:0] tdiff;
  logic [32:0]        tdiff_mag;
  logic signed [31:0] target_next;
  logic signed [32:0] ediff;
  assign tdiff       = 33'(target) - 33'(sp);
  assign tdiff_mag   = tdiff[32] ? 33'(-tdiff) : 33'(tdiff);
  assign target_next = (tdiff_mag > {1'b0, pidpc_pkg::TARGET_DEADBAND}) ? sp : target;
  assign ediff       = 33'(target_next) - 33'(meas);

  // separation band test on the newest error
  logic [31:0] e0_mag;
  assign e0_mag = e0[31] ? 32'(-e0) : 32'(e0);

  // shared multiplier operand selection
  logic signed [32:0] mul_a, mul_b;
  always_comb begin
    mul_a = 33'(e0);
    mul_b = 33'(kp);
    case (cmd.op)
      pidpc_pkg::OP_MUL_I: begin
        mul_a = 33'(e0) + 33'(e1);
        mul_b = $signed({2'b00, dt});
      end
      pidpc_pkg::OP_MUL_K: begin
        mul_a = 33'(isum);
        mul_b = 33'(ki);
      end
      pidpc_pkg::OP_MUL_D: begin
        mul_a = 33'(e0) - 33'(e1);
        mul_b = 33'(kd);
      end
      default: ;
    endcase
  end

  // trapezoid increment and clamp
  logic signed [65:0] inc_w;
  logic signed [47:0] acc;
  logic signed [47:0] ilim_s;
  logic signed [31:0] isum_next;
  assign inc_w  = prod >>> 17;
  assign ilim_s = $signed({18'd0, ilim});
  assign acc    = 48'(isum) + inc_w[47:0];
  always_comb begin
    if (acc > ilim_s) begin
      isum_next = $signed({2'b00, ilim});
    end else if (acc < -ilim_s) begin
      isum_next = -$signed({2'b00, ilim});
    end else begin
      isum_next = acc[31:0];
    end
  end

  // divider step
  logic [31:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem, num[63]};
  assign q_bit  = (rem_sh >= {1'b0, dt});

  // derivative clamp and sum
  logic [30:0]        dmag;
  logic signed [31:0] dterm;
  logic signed [65:0] usum;
  assign dmag  = (num > {33'd0, dlim}) ? dlim : num[30:0];
  assign dterm = neg ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
  assign usum  = 66'(pterm) + 66'(iterm) + 66'(dterm);

  // output shaping
  logic [31:0]        u_mag;
  logic [40:0]        mag_q8, bang_th, soft_th;
  logic signed [33:0] avg_sum;
  logic signed [31:0] drive_next;
  logic               bang_next;
  assign u_mag   = u[31] ? 32'(-u) : 32'(u);
  assign mag_q8  = {1'b0, u_mag, 8'd0};
  assign bang_th = 41'(olim) * 41'(pidpc_pkg::BANG_FRACTION_Q8);
  assign soft_th = 41'(olim) * 41'(pidpc_pkg::SOFT_FRACTION_Q8);
  assign avg_sum = 34'(u) + 34'(h0) + 34'(h1) + 34'(h2);
  always_comb begin
    bang_next  = 1'b0;
    drive_next = u;
    if (mag_q8 > bang_th) begin
      bang_next  = 1'b1;
      drive_next = u[31] ? -$signed({1'b0, olim}) : $signed({1'b0, olim});
    end else if (mag_q8 < soft_th) begin
      drive_next = avg_sum[33:2];
    end
  end

  // controller state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0; e0 <= '0; e1 <= '0; isum <= '0;
      h0 <= '0; h1 <= '0; h2 <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd.op)
        pidpc_pkg::OP_ERR: begin
          target <= target_next;
          e1     <= e0;
          e0     <= pidpc_pkg::sat32(66'(ediff));
        end
        pidpc_pkg::OP_ACC_I: if (sep) isum <= isum_next;
        default: ;
      endcase
      if (cmd.op == pidpc_pkg::OP_OUT) begin
        h2 <= h1; h1 <= h0; h0 <= drive_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      pidpc_pkg::OP_LOAD: begin
        sp   <= in_data[31:0];
        meas <= in_data[63:32];
      end
      pidpc_pkg::OP_MUL_P: begin
        prod <= mul_a * mul_b;
        sep  <= (e0_mag < {1'b0, ilim, 1'b0});
      end
      pidpc_pkg::OP_MUL_I: begin
        pterm <= pidpc_pkg::sat32(prod >>> 16);
        prod  <= mul_a * mul_b;
      end
      pidpc_pkg::OP_MUL_K: prod <= mul_a * mul_b;
      pidpc_pkg::OP_MUL_D: begin
        iterm <= sep ? pidpc_pkg::sat32(prod >>> 16) : 32'sd0;
        prod  <= mul_a * mul_b;
      end
      pidpc_pkg::OP_DIV_START: begin
        neg     <= prod[65];
        num     <= prod[65] ? 64'(-prod) : prod[63:0];
        rem     <= '0;
        div_cnt <= '0;
      end
      pidpc_pkg::OP_DIV_STEP: begin
        rem     <= q_bit ? 31'(rem_sh - {1'b0, dt}) : rem_sh[30:0];
        num     <= {num[62:0], q_bit};
        div_cnt <= div_cnt + 6'd1;
      end
      pidpc_pkg::OP_SUM: u <= pidpc_pkg::sat32(usum);
      pidpc_pkg::OP_OUT: begin
        out_drive <= drive_next;
        out_bang  <= bang_next;
      end
      default: ;
    endcase
  end

  assign status = '{div_last: (div_cnt == 6'h3F), out_busy: (out_valid && !out_ready)};

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == pidpc_pkg::OP_OUT) |-> !(out_valid && !out_ready))
    else $error("result overwritten");

  // the sum is formed only after the full quotient
  a_div_complete: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == pidpc_pkg::OP_SUM) |->
      ($past(cmd.op) == pidpc_pkg::OP_DIV_STEP && $past(div_cnt) == 6'h3F))
    else $error("divider cut short");

  // a snapped result carries the output limit
  a_bang_mag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_bang) |->
      (out_drive == {1'b0, olim} || out_drive == 32'(-$signed({1'b0, olim}))))
    else $error("snapped drive off limit");

endmodule

FILE: src/pid_position_controller_unit.sv
// ----------------------------------------------------------------------------
// pid_position_controller_unit
// Positional pid controller with integral separation and output shaping.
// ----------------------------------------------------------------------------
// One request in, one drive value out. A sample passes from acceptance to
// result through nine sequencing steps around a single shared 33x33
// multiplier plus a one-bit-per-cycle divider for the derivative term.
// A new request is taken only once the previous result has been handed to
// the output register. Configuration registers are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while the block is
// idle, as the block itself does not enforce this.
module pid_position_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // setpoint [31:0], measurement [63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // drive [31:0]
  output logic        m_axis_tuser   // bang_bang [0]
);

  pidpc_pkg::cmd_t    cmd;
  pidpc_pkg::status_t status;

  // sequencer
  pidpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and state
  pidpc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_drive (m_axis_tdata),
    .out_bang  (m_axis_tuser)
  );

endmodule
